FILE: hw/rtl/asf_pkg.sv
package asf_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_LAT      = 32;
  localparam int DIV_LAT       = 32;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
  localparam int ANG_DELAY     = 3 + SQRT_LAT + 1 + DIV_LAT - 3 - CORDIC_LAT;

  localparam logic signed [29:0] ANG_PI     = 30'sd52707179;
  localparam logic signed [29:0] ANG_TWO_PI = 30'sd105414357;

  localparam logic [1:0] REG_MAX_FORCE      = 2'd0;
  localparam logic [1:0] REG_MIN_SLOW_SPEED = 2'd1;
  localparam logic [1:0] REG_ARRIVE_RADIUS  = 2'd2;

  typedef struct packed {
    logic valid;
    logic in_radius;
    logic zero;
  } tag_t;

  function automatic logic signed [27:0] atan_entry(input int i);
    logic signed [27:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = (i <= 24) ? 28'(64'sd1 <<< (24 - i)) : 28'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/arrival_steering_force_unit.sv
// Arrival steering force unit.
// Request channel: start with robot_x/robot_y/robot_heading/goal_x/goal_y;
// a request is taken at each clock edge with start high and busy low. busy
// stays low, so one request can be taken every cycle.
// Result channel: done is high for one cycle with force_magnitude,
// relative_angle and within_radius; results leave in request order.
// The 32-stage square root and the 32-stage divider run in series; the
// CORDIC angle path runs alongside and is delayed to line up.
// Throughput: one result per cycle.
// Configuration: cfg_we/cfg_addr/cfg_data write max_force (0),
// min_slow_speed (1), arrive_radius (2); other indexes are ignored.
// Write only while no request is in flight.
// Reset (rst, synchronous) clears the pipeline valid bits and restores the
// register defaults. The receiver cannot stall; done is never held.
module arrival_steering_force_unit import asf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] robot_x,
  input  logic signed [30:0] robot_y,
  input  logic signed [15:0] robot_heading,
  input  logic signed [30:0] goal_x,
  input  logic signed [30:0] goal_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [31:0]        force_magnitude,
  output logic signed [15:0] relative_angle,
  output logic               within_radius
);

  logic [31:0] max_force;
  logic [31:0] min_slow_speed;
  logic [31:0] arrive_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_force      <= 32'd65536;
      min_slow_speed <= 32'd6554;
      arrive_radius  <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_FORCE:      max_force      <= cfg_data;
        REG_MIN_SLOW_SPEED: min_slow_speed <= cfg_data;
        REG_ARRIVE_RADIUS:  arrive_radius  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic               v1, v2, v3;
  logic signed [32:0] dx1, dy1, dx2, dy2, dx3, dy3;
  logic signed [15:0] hd1, hd2, hd3;
  logic [31:0]        ax, ay;
  logic [63:0]        ax2, ay2, sum3;

  assign ax = dx1[32] ? 32'(-dx1) : 32'(dx1);
  assign ay = dy1[32] ? 32'(-dy1) : 32'(dy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
    end
    dx1  <= 33'(goal_x) - 33'(robot_x);
    dy1  <= 33'(goal_y) - 33'(robot_y);
    hd1  <= robot_heading;
    ax2  <= ax * ax;
    ay2  <= ay * ay;
    dx2  <= dx1;
    dy2  <= dy1;
    hd2  <= hd1;
    sum3 <= ax2 + ay2;
    dx3  <= dx2;
    dy3  <= dy2;
    hd3  <= hd2;
  end

  logic        sq_valid;
  logic [31:0] distance;

  asf_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .radicand  (sum3),
    .out_valid (sq_valid),
    .root      (distance)
  );

  tag_t        tagm;
  logic [63:0] prodm;

  always_ff @(posedge clk) begin
    if (rst) begin
      tagm <= '0;
    end else begin
      tagm.valid     <= sq_valid;
      tagm.in_radius <= distance <= arrive_radius;
      tagm.zero      <= distance == 32'd0;
    end
    prodm <= max_force * distance;
  end

  tag_t        tagd;
  logic [31:0] quot;

  asf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (tagm),
    .dividend (prodm),
    .divisor  (arrive_radius),
    .out_tag  (tagd),
    .quot     (quot)
  );

  logic signed [15:0] ang_c;

  asf_cordic u_cordic (
    .clk     (clk),
    .dx      (dx3),
    .dy      (dy3),
    .heading (hd3),
    .zero    ((dx3 == 33'sd0) && (dy3 == 33'sd0)),
    .angle   (ang_c)
  );

  logic signed [15:0] angd [ANG_DELAY+1];

  assign angd[0] = ang_c;
  for (genvar i = 0; i < ANG_DELAY; i++) begin : g_adly
    always_ff @(posedge clk) begin
      angd[i+1] <= angd[i];
    end
  end

  logic [31:0] mag;

  always_comb begin
    if (tagd.zero) begin
      mag = '0;
    end else if (tagd.in_radius) begin
      mag = (quot > min_slow_speed) ? quot : min_slow_speed;
    end else begin
      mag = max_force;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tagd.valid;
    end
    force_magnitude <= mag;
    relative_angle  <= angd[ANG_DELAY];
    within_radius   <= tagd.in_radius;
  end

endmodule

FILE: hw/rtl/asf_isqrt.sv
module asf_isqrt import asf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  output logic        out_valid,
  output logic [31:0] root
);

  logic        v [SQRT_LAT+1];
  logic [63:0] n [SQRT_LAT+1];
  logic [35:0] r [SQRT_LAT+1];
  logic [31:0] q [SQRT_LAT+1];

  assign v[0] = in_valid;
  assign n[0] = radicand;
  assign r[0] = '0;
  assign q[0] = '0;

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    logic [35:0] sh;
    logic [35:0] t;
    logic        ge;
    assign sh = {r[i][33:0], n[i][63:62]};
    assign t  = {2'b00, q[i], 2'b01};
    assign ge = sh >= t;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      n[i+1] <= {n[i][61:0], 2'b00};
      r[i+1] <= ge ? sh - t : sh;
      q[i+1] <= {q[i][30:0], ge};
    end
  end

  assign out_valid = v[SQRT_LAT];
  assign root      = q[SQRT_LAT];

endmodule

FILE: hw/rtl/asf_div.sv
module asf_div import asf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tag_t        in_tag,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output tag_t        out_tag,
  output logic [31:0] quot
);

  tag_t        tg  [DIV_LAT+1];
  logic [31:0] rem [DIV_LAT+1];
  logic [31:0] low [DIV_LAT+1];
  logic [31:0] qq  [DIV_LAT+1];

  // upper half is below the divisor whenever the quotient is used
  assign tg[0]  = in_tag;
  assign rem[0] = dividend[63:32];
  assign low[0] = dividend[31:0];
  assign qq[0]  = '0;

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;
    assign sh   = {rem[i], low[i][31]};
    assign diff = sh - {1'b0, divisor};
    assign ge   = sh >= {1'b0, divisor};
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[i+1] <= '0;
      end else begin
        tg[i+1] <= tg[i];
      end
      rem[i+1] <= ge ? diff[31:0] : sh[31:0];
      low[i+1] <= {low[i][30:0], 1'b0};
      qq[i+1]  <= {qq[i][30:0], ge};
    end
  end

  assign out_tag = tg[DIV_LAT];
  assign quot    = qq[DIV_LAT];

endmodule

FILE: hw/rtl/asf_cordic.sv
module asf_cordic import asf_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  input  logic signed [15:0] heading,
  input  logic               zero,
  output logic signed [15:0] angle
);

  logic signed [35:0] x  [CORDIC_STAGES+1];
  logic signed [35:0] y  [CORDIC_STAGES+1];
  logic signed [27:0] z  [CORDIC_STAGES+1];
  logic signed [15:0] hd [CORDIC_STAGES+1];
  logic               zf [CORDIC_STAGES+1];

  // fold left half-plane onto the right
  always_ff @(posedge clk) begin
    if (dx < 0) begin
      x[0] <= -36'(dx);
      y[0] <= -36'(dy);
      z[0] <= (dy >= 0) ? 28'(ANG_PI) : 28'(-ANG_PI);
    end else begin
      x[0] <= 36'(dx);
      y[0] <= 36'(dy);
      z[0] <= '0;
    end
    hd[0] <= heading;
    zf[0] <= zero;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (y[i] >= 0) begin
        x[i+1] <= x[i] + ys;
        y[i+1] <= y[i] - xs;
        z[i+1] <= z[i] + atan_entry(i);
      end else begin
        x[i+1] <= x[i] - ys;
        y[i+1] <= y[i] + xs;
        z[i+1] <= z[i] - atan_entry(i);
      end
      hd[i+1] <= hd[i];
      zf[i+1] <= zf[i];
    end
  end

  logic signed [29:0] dir;
  logic signed [29:0] diff;
  logic signed [29:0] wrapped;
  logic signed [29:0] rnd;

  always_comb begin
    dir  = zf[CORDIC_STAGES] ? 30'sd0 : 30'(z[CORDIC_STAGES]);
    diff = dir - (30'(hd[CORDIC_STAGES]) <<< 11);
    if (diff >= ANG_PI) begin
      wrapped = diff - ANG_TWO_PI;
    end else if (diff < -ANG_PI) begin
      wrapped = diff + ANG_TWO_PI;
    end else begin
      wrapped = diff;
    end
    rnd = wrapped + 30'sd1024;
  end

  always_ff @(posedge clk) begin
    angle <= rnd[26:11];
  end

endmodule
